@@ hdl/sbf_pkg.sv @@
// Package with the shared types and constants of the source ban packet filter.
`default_nettype none
package sbf_pkg;

  localparam int unsigned TableEntriesDefault = 256;
  localparam int unsigned V4KeyW = 32;
  localparam int unsigned V6KeyW = 128;

  localparam logic [15:0] EtypeV4 = 16'h0800;
  localparam logic [15:0] EtypeV6 = 16'h86DD;
  localparam logic [15:0] DnsPort = 16'd53;
  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [7:0] ProtoIcmp6 = 8'd58;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SEL_BAN_V4    = 2'd0,
    SEL_RECENT_V4 = 2'd1,
    SEL_BAN_V6    = 2'd2,
    SEL_RECENT_V6 = 2'd3
  } sel_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_PRESENT = 2'd3
  } status_e;

  typedef struct packed {
    logic ins;
    logic del;
  } tbl_cmd_t;

  typedef struct packed {
    logic hit;
    logic free;
  } tbl_stat_t;

endpackage
`default_nettype wire

@@ hdl/sbf_table.sv @@
// Exact-match address table with parallel compare, first-free insert and delete.
`default_nettype none
module sbf_table #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned KEY_W = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [KEY_W-1:0]     key_i,
  input  wire sbf_pkg::tbl_cmd_t    cmd_i,
  output sbf_pkg::tbl_stat_t        stat_o
);
  import sbf_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [KEY_W-1:0] addr_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic hit, free;

  // Lowest matching entry and lowest empty entry.
  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (addr_q[i] == key_i)) begin
        hit = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign stat_o.hit = hit;
  assign stat_o.free = free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.ins && free) begin
        valid_q[free_idx] <= 1'b1;
      end
      if (cmd_i.del && hit) begin
        valid_q[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins && free) begin
      addr_q[free_idx] <= key_i;
    end
  end

endmodule
`default_nettype wire

@@ hdl/source_ban_packet_filter.sv @@
// Top level of the source ban packet filter.
`default_nettype none
// The filter takes one transaction per cycle while the output side keeps up:
// either a frame byte or a table insert or delete. Each transaction is held in
// an input register and handled completely when the output register is free
// or being read, where the parser fields are updated and, on the last byte of
// a frame, the captured source address is compared in parallel against every
// entry of the banned and recently banned tables of its IP version. Its verdict
// or table status is written to the output register, so a new transaction
// is accepted every cycle while the output side keeps up; the rate is set by
// the single parallel lookup per transaction. Bytes without the last flag, and
// unknown kinds, produce no result. Each table holds TABLE_ENTRIES addresses
// with a valid flag per entry that reset clears, so no clearing pass is needed.
module source_ban_packet_filter #(
  parameter int unsigned TABLE_ENTRIES = sbf_pkg::TableEntriesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  input  wire logic [1:0]  table_select_i,
  input  wire logic [63:0] address_high_i,
  input  wire logic [63:0] address_low_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             is_verdict_o,
  output logic             drop_o,
  output logic             promoted_o,
  output logic [1:0]       status_o
);
  import sbf_pkg::*;

  // Input register.
  logic s_valid_q;
  logic [1:0] kind_q, sel_q;
  logic [7:0] byte_q;
  logic last_q;
  logic [63:0] ahi_q, alo_q;

  // Parser state.
  logic [7:0] pos_q, pos_d;
  logic [15:0] etype_q, etype_d;
  logic [7:0] proto_q, proto_d;
  logic [5:0] ihl_q, ihl_d;
  logic [63:0] src_hi_q, src_hi_d, src_lo_q, src_lo_d;
  logic [15:0] sport_q, sport_d, dport_q, dport_d;
  logic [7:0] flags_q, flags_d;

  // Output register.
  logic out_valid_q;
  logic verd_q, drop_q, prom_q;
  logic [1:0] status_q;

  logic adv, go, is_pkt;
  logic has_res, res_verd, res_drop, res_prom;
  logic [1:0] res_status;

  // Captured fields after this byte, before any end-of-frame clearing.
  logic [15:0] etype_n;
  logic [7:0] proto_n, flags_n, trel;
  logic [5:0] ihl_n;
  logic [63:0] hi_n, lo_n;
  logic [15:0] sport_n, dport_n;
  logic [6:0] toff;
  logic [8:0] flen;
  logic is4, is6, udp_full, look;

  tbl_cmd_t cmd [4];
  tbl_stat_t stat [4];
  logic [V4KeyW-1:0] key4;
  logic [V6KeyW-1:0] key6;

  assign adv = !out_valid_q || out_ready_i;
  assign go = s_valid_q && adv;
  assign in_ready_o = !s_valid_q || adv;
  assign is_pkt = (kind_q == KIND_BYTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      byte_q <= data_byte_i;
      last_q <= last_i;
      sel_q <= table_select_i;
      ahi_q <= address_high_i;
      alo_q <= address_low_i;
    end
  end

  // Header capture for the byte at the current frame position.
  always_comb begin
    etype_n = etype_q;
    proto_n = proto_q;
    ihl_n = ihl_q;
    hi_n = src_hi_q;
    lo_n = src_lo_q;
    sport_n = sport_q;
    dport_n = dport_q;
    flags_n = flags_q;
    trel = '0;
    if (pos_q == 8'd12) etype_n = {byte_q, 8'h00};
    if (pos_q == 8'd13) etype_n = etype_n | {8'h00, byte_q};
    is4 = (etype_n == EtypeV4);
    is6 = (etype_n == EtypeV6);
    if (is4) begin
      if (pos_q == 8'd14) begin
        ihl_n = ({byte_q[3:0], 2'b00} < 6'd20) ? 6'd20 : {byte_q[3:0], 2'b00};
      end
      if (pos_q == 8'd23) proto_n = byte_q;
      if (pos_q >= 8'd26 && pos_q <= 8'd29) lo_n = {32'h0, src_lo_q[23:0], byte_q};
    end else if (is6) begin
      if (pos_q == 8'd20) proto_n = byte_q;
      if (pos_q >= 8'd22 && pos_q <= 8'd29) hi_n = {src_hi_q[55:0], byte_q};
      if (pos_q >= 8'd30 && pos_q <= 8'd37) lo_n = {src_lo_q[55:0], byte_q};
    end
    toff = is4 ? (7'd14 + {1'b0, ihl_n}) : 7'd54;
    if ((is4 || is6) && (pos_q >= {1'b0, toff})) begin
      trel = pos_q - {1'b0, toff};
      if (trel <= 8'd1) sport_n = {sport_q[7:0], byte_q};
      if (trel == 8'd2 || trel == 8'd3) dport_n = {dport_q[7:0], byte_q};
      if (trel == 8'd13) flags_n = byte_q;
    end
    flen = {1'b0, pos_q} + 9'd1;
    udp_full = flen >= ({2'b00, toff} + 9'd8);
    look = (flen >= 9'd14) &&
           ((is4 && flen >= 9'd34) ||
            (is6 && flen >= 9'd54 &&
             !(proto_n == ProtoUdp && udp_full &&
               (dport_n == DnsPort || sport_n == DnsPort)) &&
             !(hi_n == 64'd0 && lo_n == 64'd1)));
  end

  assign key4 = is_pkt ? lo_n[31:0] : alo_q[31:0];
  assign key6 = is_pkt ? {hi_n, lo_n} : {ahi_q, alo_q};

  // Verdict, promotion and table operations.
  always_comb begin
    logic bhit, rhit, bfree, promote;
    logic [1:0] sb;
    for (int i = 0; i < 4; i++) cmd[i] = '0;
    has_res = 1'b0;
    res_verd = 1'b0;
    res_drop = 1'b0;
    res_prom = 1'b0;
    res_status = ST_OK;
    promote = 1'b0;
    sb = is4 ? SEL_BAN_V4 : SEL_BAN_V6;
    bhit = stat[sb].hit;
    bfree = stat[sb].free;
    rhit = stat[sb + 2'd1].hit;
    case (kind_q)
      KIND_BYTE: begin
        if (last_q) begin
          has_res = 1'b1;
          res_verd = 1'b1;
          if (look) begin
            if (bhit) begin
              res_drop = 1'b1;
            end else if (rhit) begin
              if (proto_n == ProtoUdp) begin
                if (!(udp_full && dport_n == DnsPort)) begin
                  promote = 1'b1;
                  res_drop = 1'b1;
                end
              end else if (proto_n == (is4 ? ProtoIcmp : ProtoIcmp6)) begin
                promote = 1'b1;
                res_drop = 1'b1;
              end else if (proto_n == ProtoTcp) begin
                if ((flen >= ({2'b00, toff} + 9'd20)) && ((flags_n & 8'h05) != 8'h00)) begin
                  promote = 1'b1;
                end
              end
            end
          end
          if (promote) begin
            cmd[sb].ins = go;
            cmd[sb + 2'd1].del = go;
            res_prom = bfree;
          end
        end
      end
      KIND_INSERT: begin
        has_res = 1'b1;
        if (stat[sel_q].hit) begin
          res_status = ST_PRESENT;
        end else if (stat[sel_q].free) begin
          cmd[sel_q].ins = go;
        end else begin
          res_status = ST_FULL;
        end
      end
      KIND_DELETE: begin
        has_res = 1'b1;
        if (stat[sel_q].hit) begin
          cmd[sel_q].del = go;
        end else begin
          res_status = ST_ABSENT;
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  sbf_table #(.ENTRIES(TABLE_ENTRIES), .KEY_W(V4KeyW)) u_ban_v4 (
    .clk_i, .rst_ni, .key_i(key4), .cmd_i(cmd[SEL_BAN_V4]), .stat_o(stat[SEL_BAN_V4])
  );
  sbf_table #(.ENTRIES(TABLE_ENTRIES), .KEY_W(V4KeyW)) u_recent_v4 (
    .clk_i, .rst_ni, .key_i(key4), .cmd_i(cmd[SEL_RECENT_V4]), .stat_o(stat[SEL_RECENT_V4])
  );
  sbf_table #(.ENTRIES(TABLE_ENTRIES), .KEY_W(V6KeyW)) u_ban_v6 (
    .clk_i, .rst_ni, .key_i(key6), .cmd_i(cmd[SEL_BAN_V6]), .stat_o(stat[SEL_BAN_V6])
  );
  sbf_table #(.ENTRIES(TABLE_ENTRIES), .KEY_W(V6KeyW)) u_recent_v6 (
    .clk_i, .rst_ni, .key_i(key6), .cmd_i(cmd[SEL_RECENT_V6]), .stat_o(stat[SEL_RECENT_V6])
  );

  // Next parser state: advance on every byte, clear after the last one.
  always_comb begin
    pos_d = pos_q;
    etype_d = etype_q;
    proto_d = proto_q;
    ihl_d = ihl_q;
    src_hi_d = src_hi_q;
    src_lo_d = src_lo_q;
    sport_d = sport_q;
    dport_d = dport_q;
    flags_d = flags_q;
    if (go && is_pkt) begin
      if (last_q) begin
        pos_d = '0;
        etype_d = '0;
        proto_d = '0;
        ihl_d = 6'd20;
        src_hi_d = '0;
        src_lo_d = '0;
        sport_d = '0;
        dport_d = '0;
        flags_d = '0;
      end else begin
        pos_d = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
        etype_d = etype_n;
        proto_d = proto_n;
        ihl_d = ihl_n;
        src_hi_d = hi_n;
        src_lo_d = lo_n;
        sport_d = sport_n;
        dport_d = dport_n;
        flags_d = flags_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      etype_q <= '0;
      proto_q <= '0;
      ihl_q <= 6'd20;
      src_hi_q <= '0;
      src_lo_q <= '0;
      sport_q <= '0;
      dport_q <= '0;
      flags_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      etype_q <= etype_d;
      proto_q <= proto_d;
      ihl_q <= ihl_d;
      src_hi_q <= src_hi_d;
      src_lo_q <= src_lo_d;
      sport_q <= sport_d;
      dport_q <= dport_d;
      flags_q <= flags_d;
      if (go) begin
        out_valid_q <= has_res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      verd_q <= res_verd;
      drop_q <= res_drop;
      prom_q <= res_prom;
      status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_verdict_o = verd_q;
  assign drop_o = drop_q;
  assign promoted_o = prom_q;
  assign status_o = status_q;

  // A verdict always carries an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_verdict_o) |-> (status_o == ST_OK))
    else $error("verdict with non-ok status");

  // A table status never reports a drop or a promotion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_verdict_o) |-> (!drop_o && !promoted_o))
    else $error("table status with verdict flags");

  // A waiting result is not overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o) && $stable(drop_o)))
    else $error("pending result changed");

endmodule
`default_nettype wire

@@ bench/sbf_verdict_checker.sv @@
// Checker for the source ban packet filter: it predicts each verdict and table status and compares.
`timescale 1ns / 1ps
module sbf_verdict_checker
  import sbf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  input  wire logic [1:0]  table_select_i,
  input  wire logic [63:0] address_high_i,
  input  wire logic [63:0] address_low_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        is_verdict_i,
  input  wire logic        drop_i,
  input  wire logic        promoted_i,
  input  wire logic [1:0]  status_i,
  output int               errors_o,
  output int               pending_o
);

  localparam int Slots = 256;

  typedef struct packed {
    logic    verdict;
    logic    drop;
    logic    promoted;
    status_e status;
  } outcome_t;

  outcome_t outcome_q[$];

  // Address tables; IPv4 entries keep a zero upper word and only 32 low bits.
  bit [63:0] addr_hi[4][Slots];
  bit [63:0] addr_lo[4][Slots];
  bit        slot_used[4][Slots];

  // Parser state of the frame in flight.
  int        byte_pos;
  bit [15:0] etype;
  bit [7:0]  proto;
  int        ihl_bytes;
  bit [63:0] src_hi;
  bit [63:0] src_lo;
  bit [15:0] sport;
  bit [15:0] dport;
  bit [7:0]  tcp_flags;

  int errors;

  assign errors_o  = errors;
  assign pending_o = outcome_q.size();

  function automatic void clear_frame();
    byte_pos  = 0;
    etype     = '0;
    proto     = '0;
    ihl_bytes = 20;
    src_hi    = '0;
    src_lo    = '0;
    sport     = '0;
    dport     = '0;
    tcp_flags = '0;
  endfunction

  function automatic int find_slot(sel_e s, bit [63:0] hi, bit [63:0] lo);
    for (int i = 0; i < Slots; i++)
      if (slot_used[s][i] && addr_hi[s][i] == hi && addr_lo[s][i] == lo) return i;
    return -1;
  endfunction

  function automatic status_e add_entry(sel_e s, bit [63:0] hi, bit [63:0] lo);
    if (find_slot(s, hi, lo) >= 0) return ST_PRESENT;
    for (int i = 0; i < Slots; i++) begin
      if (!slot_used[s][i]) begin
        addr_hi[s][i]   = hi;
        addr_lo[s][i]   = lo;
        slot_used[s][i] = 1'b1;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  function automatic status_e drop_entry(sel_e s, bit [63:0] hi, bit [63:0] lo);
    int i;
    i = find_slot(s, hi, lo);
    if (i < 0) return ST_ABSENT;
    slot_used[s][i] = 1'b0;
    return ST_OK;
  endfunction

  function automatic int transport_start();
    return (etype == EtypeV4) ? 14 + ihl_bytes : 54;
  endfunction

  function automatic void parse_byte(int p, bit [7:0] b);
    int t;
    if (p == 12) etype = {b, 8'h00};
    if (p == 13) etype[7:0] = b;
    if (etype == EtypeV4) begin
      if (p == 14) ihl_bytes = (b[3:0] * 4 < 20) ? 20 : b[3:0] * 4;
      if (p == 23) proto = b;
      if (p >= 26 && p <= 29) src_lo = {32'h0, src_lo[23:0], b};
    end else if (etype == EtypeV6) begin
      if (p == 20) proto = b;
      if (p >= 22 && p <= 29) src_hi = {src_hi[55:0], b};
      if (p >= 30 && p <= 37) src_lo = {src_lo[55:0], b};
    end else begin
      return;
    end
    if (p >= transport_start()) begin
      t = p - transport_start();
      if (t <= 1) sport = {sport[7:0], b};
      if (t == 2 || t == 3) dport = {dport[7:0], b};
      if (t == 13) tcp_flags = b;
    end
  endfunction

  // The recent entry goes away even when the banned table has no room left.
  function automatic bit move_to_banned(sel_e s, int r, bit [63:0] hi, bit [63:0] lo);
    slot_used[sel_e'(s + 1)][r] = 1'b0;
    return add_entry(s, hi, lo) == ST_OK;
  endfunction

  function automatic void judge_frame(int len, output bit drop, output bit promoted);
    int        t;
    int        r;
    bit        udp_whole;
    bit [63:0] hi;
    bit [63:0] lo;
    sel_e      s;
    t         = transport_start();
    udp_whole = len >= t + 8;
    drop      = 1'b0;
    promoted  = 1'b0;
    if (len < 14) return;
    if (etype == EtypeV4) begin
      if (len < 34) return;
      hi = '0;
      lo = {32'h0, src_lo[31:0]};
      s  = SEL_BAN_V4;
    end else if (etype == EtypeV6) begin
      if (len < 54) return;
      // DNS traffic and the loopback source always pass on IPv6.
      if (proto == ProtoUdp && udp_whole && (dport == DnsPort || sport == DnsPort)) return;
      if (src_hi == 0 && src_lo == 1) return;
      hi = src_hi;
      lo = src_lo;
      s  = SEL_BAN_V6;
    end else begin
      return;
    end
    if (find_slot(s, hi, lo) >= 0) begin
      drop = 1'b1;
      return;
    end
    r = find_slot(sel_e'(s + 1), hi, lo);
    if (r < 0) return;
    if (proto == ProtoUdp) begin
      if (udp_whole && dport == DnsPort) return;
      promoted = move_to_banned(s, r, hi, lo);
      drop     = 1'b1;
    end else if (proto == ((s == SEL_BAN_V4) ? ProtoIcmp : ProtoIcmp6)) begin
      promoted = move_to_banned(s, r, hi, lo);
      drop     = 1'b1;
    end else if (proto == ProtoTcp) begin
      if (len >= t + 20 && (tcp_flags & 8'h05) != 0) promoted = move_to_banned(s, r, hi, lo);
    end
  endfunction

  task automatic report(string what, int want, int got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  initial begin
    errors = 0;
    clear_frame();
  end

  // Sampled mid-cycle, where every handshake signal is settled for the next edge.
  always @(negedge clk_i) begin
    outcome_t  want;
    bit        d;
    bit        pr;
    int        p;
    sel_e      s;
    bit [63:0] hi;
    bit [63:0] lo;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          report("unexpected transaction, is_verdict", 0, is_verdict_i);
        end else begin
          want = outcome_q.pop_front();
          if (is_verdict_i !== want.verdict) report("is_verdict", want.verdict, is_verdict_i);
          if (drop_i !== want.drop) report("drop", want.drop, drop_i);
          if (promoted_i !== want.promoted) report("promoted", want.promoted, promoted_i);
          if (status_i !== want.status) report("status", want.status, status_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          KIND_BYTE: begin
            p = byte_pos;
            parse_byte(p, data_byte_i);
            if (byte_pos < 255) byte_pos++;
            if (last_i) begin
              judge_frame(p + 1, d, pr);
              clear_frame();
              outcome_q.push_back('{1'b1, d, pr, ST_OK});
            end
          end
          KIND_INSERT, KIND_DELETE: begin
            s  = sel_e'(table_select_i);
            hi = address_high_i;
            lo = address_low_i;
            if (s == SEL_BAN_V4 || s == SEL_RECENT_V4) begin
              hi = '0;
              lo = {32'h0, lo[31:0]};
            end
            want = '{1'b0, 1'b0, 1'b0, ST_OK};
            want.status = (kind_i == KIND_INSERT) ? add_entry(s, hi, lo) : drop_entry(s, hi, lo);
            outcome_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ bench/source_ban_packet_filter_tb.sv @@
// Testbench top for the source ban packet filter: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module source_ban_packet_filter_tb;
  import sbf_pkg::*;

  // The kind code that the block has to ignore.
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int         CycleLimit = 400000;
  localparam int         VerV4 = 0;
  localparam int         VerV6 = 1;
  localparam int         VerOther = 2;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_BYTE;
  logic [7:0]  data_byte_i = '0;
  logic        last_i = 1'b0;
  logic [1:0]  table_select_i = SEL_BAN_V4;
  logic [63:0] address_high_i = '0;
  logic [63:0] address_low_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        is_verdict_o;
  logic        drop_o;
  logic        promoted_o;
  logic [1:0]  status_o;

  int errors;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int burst_left = 0;

  // Small address pools, so that frames really hit the table entries.
  logic [31:0] v4_pool[8];
  logic [63:0] v6_pool_hi[8];
  logic [63:0] v6_pool_lo[8];

  source_ban_packet_filter u_top (.*);

  sbf_verdict_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .last_i        (last_i),
    .table_select_i(table_select_i),
    .address_high_i(address_high_i),
    .address_low_i (address_low_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_verdict_i  (is_verdict_o),
    .drop_i        (drop_o),
    .promoted_i    (promoted_o),
    .status_i      (status_o),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The receiver moves through three stall patterns: always ready, coin flips, and a
  // fixed one-in-four stall. The cycle counter also ends a run that hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    case ((cycles / 300) % 3)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= (cycles % 4) != 0;
    endcase
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drives one transaction and returns at the edge where it is accepted. The
  // sender works in bursts; between most bursts it drops valid for a random gap.
  task automatic send_txn(logic [1:0] kind, logic [7:0] b, logic last, logic [1:0] sel,
                          logic [63:0] hi, logic [63:0] lo);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    data_byte_i    <= b;
    last_i         <= last;
    table_select_i <= sel;
    address_high_i <= hi;
    address_low_i  <= lo;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  // A table transaction; for IPv4 tables the ignored address bits carry noise.
  task automatic send_table_op(logic [1:0] kind, sel_e sel, int idx);
    if (sel == SEL_BAN_V4 || sel == SEL_RECENT_V4)
      send_txn(kind, 8'($urandom), 1'($urandom), sel, {$urandom, $urandom},
               {$urandom, v4_pool[idx]});
    else
      send_txn(kind, 8'($urandom), 1'($urandom), sel, v6_pool_hi[idx], v6_pool_lo[idx]);
  endtask

  task automatic random_table_op();
    sel_e sel;
    sel = sel_e'($urandom_range(0, 3));
    send_table_op(($urandom_range(0, 9) < 6) ? KIND_INSERT : KIND_DELETE, sel,
                  $urandom_range(0, 7));
  endtask

  function automatic int transport_of(int ver, int ihl);
    if (ver == VerV4) return 14 + ((ihl * 4 < 20) ? 20 : ihl * 4);
    return 54;
  endfunction

  // Builds a frame of len bytes with the given header fields and sends it; now
  // and then a table transaction slips in between two of its bytes.
  task automatic send_frame(int ver, int src, logic [7:0] proto, int ihl, int len,
                            logic [15:0] sp, logic [15:0] dp, logic [7:0] flags);
    logic [7:0]  fb[300];
    logic [15:0] et;
    int          t;
    for (int i = 0; i < 300; i++) fb[i] = 8'($urandom);
    t = transport_of(ver, ihl);
    if (ver == VerV4) begin
      et = EtypeV4;
      fb[14] = {4'h4, ihl[3:0]};
      fb[23] = proto;
      {fb[26], fb[27], fb[28], fb[29]} = v4_pool[src];
    end else if (ver == VerV6) begin
      et = EtypeV6;
      fb[20] = proto;
      for (int i = 0; i < 8; i++) begin
        fb[22 + i] = v6_pool_hi[src][63 - 8 * i -: 8];
        fb[30 + i] = v6_pool_lo[src][63 - 8 * i -: 8];
      end
    end else begin
      et = 16'($urandom);
      if (et == EtypeV4 || et == EtypeV6) et = 16'h0806;
    end
    {fb[12], fb[13]} = et;
    {fb[t], fb[t + 1]} = sp;
    {fb[t + 2], fb[t + 3]} = dp;
    fb[t + 13] = flags;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 40) == 0) random_table_op();
      send_txn(KIND_BYTE, fb[i], i == len - 1, 2'($urandom), {$urandom, $urandom},
               {$urandom, $urandom});
    end
    frames_sent++;
  endtask

  task automatic random_frame();
    int          ver;
    int          ihl;
    int          t;
    int          len;
    int          pick;
    logic [7:0]  proto;
    logic [15:0] sp;
    logic [15:0] dp;
    pick = $urandom_range(0, 19);
    ver  = (pick < 9) ? VerV4 : (pick < 17) ? VerV6 : VerOther;
    ihl  = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
    case ($urandom_range(0, 5))
      0: proto = ProtoUdp;
      1: proto = ProtoUdp;
      2: proto = ProtoTcp;
      3: proto = ProtoIcmp;
      4: proto = ProtoIcmp6;
      default: proto = 8'($urandom);
    endcase
    sp = ($urandom_range(0, 4) == 0) ? DnsPort : 16'($urandom);
    dp = ($urandom_range(0, 4) == 0) ? DnsPort : 16'($urandom);
    t  = transport_of(ver, ihl);
    pick = $urandom_range(0, 39);
    if (pick < 20) len = t + $urandom_range(20, 30);
    else if (pick < 28) len = t + $urandom_range(8, 19);
    else if (pick < 38) len = $urandom_range(1, t + 7);
    else len = $urandom_range(256, 280);
    send_frame(ver, $urandom_range(0, 7), proto, ihl, len, sp, dp, 8'($urandom));
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      v4_pool[i]    = {8'hC6, 24'($urandom)};
      v6_pool_hi[i] = {$urandom, $urandom};
      v6_pool_lo[i] = {$urandom, $urandom};
    end
    // The last IPv6 pool entry is the loopback address ::1.
    v6_pool_hi[7] = '0;
    v6_pool_lo[7] = 64'd1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: status codes, promotion by UDP, short frames, the IPv6 DNS
    // and loopback bypasses, TCP FIN and an ignored kind.
    send_table_op(KIND_INSERT, SEL_RECENT_V4, 0);
    send_table_op(KIND_INSERT, SEL_RECENT_V4, 0);
    send_table_op(KIND_DELETE, SEL_BAN_V4, 1);
    send_table_op(KIND_INSERT, SEL_RECENT_V6, 1);
    send_table_op(KIND_INSERT, SEL_BAN_V6, 7);
    send_table_op(KIND_INSERT, SEL_RECENT_V6, 2);
    send_table_op(KIND_INSERT, SEL_RECENT_V4, 3);
    send_txn(KindUnused, 8'hFF, 1'b1, SEL_RECENT_V6, '1, '1);
    send_frame(VerV4, 0, ProtoUdp, 5, 42, 16'd1000, 16'd80, 8'h00);
    send_frame(VerV4, 0, ProtoTcp, 2, 13, 16'd1, 16'd2, 8'h00);
    send_frame(VerV4, 0, ProtoTcp, 15, 33, 16'd1, 16'd2, 8'h00);
    send_frame(VerV6, 1, ProtoUdp, 5, 62, DnsPort, 16'd999, 8'h00);
    send_frame(VerV6, 7, ProtoIcmp6, 5, 60, 16'd0, 16'd0, 8'h00);
    send_frame(VerV6, 1, ProtoUdp, 5, 58, 16'd7, DnsPort, 8'h00);
    send_frame(VerV6, 2, ProtoTcp, 5, 74, 16'd7, 16'd8, 8'h04);
    send_frame(VerV4, 3, ProtoTcp, 5, 54, 16'd7, 16'd8, 8'h01);

    // Fill the banned IPv4 table to overflow, promote into the full table, then
    // empty it again.
    for (int i = 0; i < 257; i++)
      send_txn(KIND_INSERT, 8'($urandom), 1'b0, SEL_BAN_V4, {$urandom, $urandom},
               {$urandom, 32'h0A000000 + i});
    send_table_op(KIND_INSERT, SEL_RECENT_V4, 4);
    send_frame(VerV4, 4, ProtoIcmp, 5, 40, 16'd0, 16'd0, 8'h00);
    send_frame(VerV4, 4, ProtoIcmp, 5, 40, 16'd0, 16'd0, 8'h00);
    for (int i = 0; i < 257; i++)
      send_txn(KIND_DELETE, 8'($urandom), 1'b1, SEL_BAN_V4, {$urandom, $urandom},
               {$urandom, 32'h0A000000 + i});

    // Random part: mostly well-formed frames and table traffic, with noise bytes
    // and ignored kinds mixed in.
    items_sent = 0;
    frames_sent = 0;
    while (items_sent < 650) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: random_frame();
        11, 12, 13, 14, 15, 16: random_table_op();
        17: send_txn(KindUnused, 8'($urandom), 1'($urandom), 2'($urandom),
                     {$urandom, $urandom}, {$urandom, $urandom});
        default: send_txn(KIND_BYTE, 8'($urandom), 1'($urandom_range(0, 1)), 2'($urandom),
                          {$urandom, $urandom}, {$urandom, $urandom});
      endcase
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ source_ban_packet_filter.f @@
hdl/sbf_pkg.sv
hdl/sbf_table.sv
hdl/source_ban_packet_filter.sv
bench/sbf_verdict_checker.sv
bench/source_ban_packet_filter_tb.sv
